### hw/rtl/hgsa_pkg.sv
// Package for the hash group sum aggregator.
// Widths, codes and the memory request types shared by all modules.
// No dependencies.
package hgsa_pkg;

    localparam int SLOTS   = 1024;                 // built table depth
    localparam int SLOT_AW = $clog2(SLOTS);        // slot address bits
    localparam int SLOT_CW = $clog2(SLOTS + 1);    // slot count bits

    localparam int KEY_W    = 32;
    localparam int PRICE_W  = 32;
    localparam int SUM_W    = 48;
    localparam int SIDX_W   = 10;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 3;
    localparam int TS_W     = 11;                  // table_slots register
    localparam int ENTRY_W  = KEY_W + SUM_W;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 96;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_TABLE_SLOTS = 1'b0;       // word index of table_slots
    localparam logic [TS_W-1:0] TABLE_SLOTS_RST = TS_W'(1024);

    localparam logic [31:0] HASH_MUL  = 32'h9e37_79b9;
    localparam logic [KEY_W-1:0] VACANT_KEY = '1;
    localparam logic [SUM_W-1:0] SUM_MAX   = '1;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_UPDATED  = 3'd0;
    localparam logic [STATUS_W-1:0] STS_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] STS_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STS_RESERVED = 3'd3;
    localparam logic [STATUS_W-1:0] STS_RD_EMPTY = 3'd4;
    localparam logic [STATUS_W-1:0] STS_RD_OCC   = 3'd5;

    localparam logic MODE_ACC  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic               rd_en;
        logic [SLOT_AW-1:0] rd_addr;
        logic               wr_en;
        logic [SLOT_AW-1:0] wr_addr;
        logic [KEY_W-1:0]   wr_key;
        logic [SUM_W-1:0]   wr_sum;
    } t_mem_req;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [SUM_W-1:0] sum;
    } t_mem_rsp;

endpackage

### hw/rtl/hash_group_sum_aggregator_top.sv
// Top level of the hash group sum aggregator: stream ports, APB register,
// probe sequencer. Depends on hgsa_pkg, hgsa_hash and hgsa_mem.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------
//  s_axis    | in        | s_axis_tvalid/tready    | tuser mode; tdata key,price,slot_index
//  m_axis    | out       | m_axis_tvalid/tready    | tuser status; tdata slot,key_out,sum_out
//  apb       | in/out    | psel/penable, pready=1  | table_slots at byte address 0
//
// After reset a clearing pass writes every key to empty, with s_axis_tready
// low; register writes are taken throughout.
// Read item: accept, memory read, result. Reserved key or a read beyond the
// slots in use: accept, result.
// Accumulate item: accept, two hash multiply stages, one probe per cycle
// through the single memory read port, result.
// One item is in flight at a time; a result waiting on m_axis does not stop
// the next item being accepted, only its own result being loaded.
module hash_group_sum_aggregator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [hgsa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // key[31:0] price[63:32] slot_index[73:64]
    input  logic                                s_axis_tuser,  // mode[0]
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [hgsa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // slot[9:0] key_out[41:10] sum_out[89:42]
    output logic [hgsa_pkg::STATUS_W-1:0]       m_axis_tuser,  // status[2:0]
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hgsa_pkg::PADDR_W-1:0]        paddr,
    input  logic [hgsa_pkg::PDATA_W-1:0]        pwdata,
    output logic [hgsa_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_HASH  = 6'b000100,
        ST_CHECK = 6'b001000,
        ST_RDATA = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [hgsa_pkg::TS_W-1:0]     r_table_slots;
    logic                          w_cfg_wr;

    // item held for the whole transaction
    logic [hgsa_pkg::KEY_W-1:0]    r_key, n_key;
    logic [hgsa_pkg::PRICE_W-1:0]  r_price, n_price;
    logic [hgsa_pkg::SLOT_CW-1:0]  r_s, n_s;
    logic [hgsa_pkg::SIDX_W-1:0]   r_sidx, n_sidx;
    logic [hgsa_pkg::SLOT_AW-1:0]  r_idx, n_idx;
    logic [hgsa_pkg::SLOT_AW-1:0]  r_home, n_home;
    logic [hgsa_pkg::SLOT_CW-1:0]  r_cnt, n_cnt;
    logic [hgsa_pkg::KEY_W-1:0]    r_hkey, n_hkey;
    logic [hgsa_pkg::SUM_W-1:0]    r_hsum, n_hsum;

    // pending result
    logic [hgsa_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [hgsa_pkg::SLOT_W-1:0]   r_res_slot, n_res_slot;
    logic [hgsa_pkg::KEY_W-1:0]    r_res_key, n_res_key;
    logic [hgsa_pkg::SUM_W-1:0]    r_res_sum, n_res_sum;

    // output register
    logic                          r_m_valid, n_m_valid;
    logic [hgsa_pkg::STATUS_W-1:0] r_m_status;
    logic [hgsa_pkg::SLOT_W-1:0]   r_m_slot;
    logic [hgsa_pkg::KEY_W-1:0]    r_m_key;
    logic [hgsa_pkg::SUM_W-1:0]    r_m_sum;
    logic                          w_m_load;

    // input unpacking
    logic                          w_in_mode;
    logic [hgsa_pkg::KEY_W-1:0]    w_in_key;
    logic [hgsa_pkg::PRICE_W-1:0]  w_in_price;
    logic [hgsa_pkg::SIDX_W-1:0]   w_in_sidx;
    logic                          w_accept;

    logic [hgsa_pkg::SLOT_CW-1:0]  w_s_clamp;
    logic [hgsa_pkg::SLOT_CW-1:0]  w_ts_ext;

    // hash and memory
    logic                          w_hash_start;
    logic                          w_hash_valid;
    logic [hgsa_pkg::SLOT_AW-1:0]  w_hash_home;
    hgsa_pkg::t_mem_req            w_req;
    hgsa_pkg::t_mem_rsp            w_rsp;
    logic                          w_mem_busy;

    // probe decode
    logic                          w_hit;
    logic                          w_empty;
    logic                          w_last;
    logic [hgsa_pkg::SUM_W:0]      w_add;
    logic [hgsa_pkg::SUM_W-1:0]    w_sat;
    logic [hgsa_pkg::SLOT_CW-1:0]  w_idx_inc;
    logic [hgsa_pkg::SLOT_AW-1:0]  w_idx_next;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[hgsa_pkg::PADDR_W-1:2] == hgsa_pkg::REG_TABLE_SLOTS);
    assign prdata   = (paddr[hgsa_pkg::PADDR_W-1:2] == hgsa_pkg::REG_TABLE_SLOTS)
                      ? hgsa_pkg::PDATA_W'(r_table_slots) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_slots <= hgsa_pkg::TABLE_SLOTS_RST;
        end else if (w_cfg_wr) begin
            r_table_slots <= pwdata[hgsa_pkg::TS_W-1:0];
        end
    end

    // slots in use: below 2 acts as 2, above the built depth as the depth
    assign w_ts_ext = hgsa_pkg::SLOT_CW'(r_table_slots);
    always_comb begin
        if (r_table_slots < hgsa_pkg::TS_W'(2)) begin
            w_s_clamp = hgsa_pkg::SLOT_CW'(2);
        end else if ({1'b0, r_table_slots} > 12'(hgsa_pkg::SLOTS)) begin
            w_s_clamp = hgsa_pkg::SLOT_CW'(hgsa_pkg::SLOTS);
        end else begin
            w_s_clamp = w_ts_ext;
        end
    end

    // ---------------- input stream ----------------
    assign w_in_mode  = s_axis_tuser;
    assign w_in_key   = s_axis_tdata[31:0];
    assign w_in_price = s_axis_tdata[63:32];
    assign w_in_sidx  = s_axis_tdata[73:64];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // ---------------- submodules ----------------
    assign w_hash_start = w_accept && (w_in_mode == hgsa_pkg::MODE_ACC) &&
                          (w_in_key != hgsa_pkg::VACANT_KEY);

    hgsa_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_key   (w_in_key),
        .i_s_m1  (hgsa_pkg::SLOT_AW'(w_s_clamp - 1'b1)),
        .o_valid (w_hash_valid),
        .o_home  (w_hash_home)
    );

    hgsa_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp),
        .o_busy  (w_mem_busy)
    );

    // ---------------- probe decode ----------------
    assign w_hit      = (w_rsp.key == r_key);
    assign w_empty    = (w_rsp.key == hgsa_pkg::VACANT_KEY);
    assign w_last     = (r_cnt == r_s - 1'b1);
    assign w_add      = {1'b0, w_rsp.sum} + (hgsa_pkg::SUM_W + 1)'(r_price);
    assign w_sat      = w_add[hgsa_pkg::SUM_W] ? hgsa_pkg::SUM_MAX
                                               : w_add[hgsa_pkg::SUM_W-1:0];
    assign w_idx_inc  = hgsa_pkg::SLOT_CW'(r_idx) + 1'b1;
    assign w_idx_next = (w_idx_inc >= r_s) ? '0 : w_idx_inc[hgsa_pkg::SLOT_AW-1:0];

    // ---------------- sequencer ----------------
    assign w_m_load = (r_state == ST_DONE) && (!r_m_valid || m_axis_tready);

    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_price      = r_price;
        n_s          = r_s;
        n_sidx       = r_sidx;
        n_idx        = r_idx;
        n_home       = r_home;
        n_cnt        = r_cnt;
        n_hkey       = r_hkey;
        n_hsum       = r_hsum;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_key    = r_res_key;
        n_res_sum    = r_res_sum;
        w_req        = '0;

        case (r_state)
            ST_CLEAR: begin
                if (!w_mem_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_key   = w_in_key;
                    n_price = w_in_price;
                    n_s     = w_s_clamp;
                    n_sidx  = w_in_sidx;
                    if (w_in_mode == hgsa_pkg::MODE_READ) begin
                        if (hgsa_pkg::SLOT_CW'(w_in_sidx) >= w_s_clamp) begin
                            // beyond slots in use: reads as empty, no memory access
                            n_res_status = hgsa_pkg::STS_RD_EMPTY;
                            n_res_slot   = w_in_sidx;
                            n_res_key    = hgsa_pkg::VACANT_KEY;
                            n_res_sum    = '0;
                            n_state      = ST_DONE;
                        end else begin
                            w_req.rd_en   = 1'b1;
                            w_req.rd_addr = hgsa_pkg::SLOT_AW'(w_in_sidx);
                            n_state       = ST_RDATA;
                        end
                    end else if (w_in_key == hgsa_pkg::VACANT_KEY) begin
                        n_res_status = hgsa_pkg::STS_RESERVED;
                        n_res_slot   = '0;
                        n_res_key    = hgsa_pkg::VACANT_KEY;
                        n_res_sum    = '0;
                        n_state      = ST_DONE;
                    end else begin
                        n_state = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                if (w_hash_valid) begin
                    // first probe goes straight out at the home slot
                    w_req.rd_en   = 1'b1;
                    w_req.rd_addr = w_hash_home;
                    n_idx         = w_hash_home;
                    n_home        = w_hash_home;
                    n_cnt         = '0;
                    n_state       = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_cnt == '0) begin
                    n_hkey = w_rsp.key;
                    n_hsum = w_rsp.sum;
                end
                if (w_hit) begin
                    w_req.wr_en   = 1'b1;
                    w_req.wr_addr = r_idx;
                    w_req.wr_key  = r_key;
                    w_req.wr_sum  = w_sat;
                    n_res_status  = hgsa_pkg::STS_UPDATED;
                    n_res_slot    = hgsa_pkg::SLOT_W'(r_idx);
                    n_res_key     = r_key;
                    n_res_sum     = w_sat;
                    n_state       = ST_DONE;
                end else if (w_empty) begin
                    w_req.wr_en   = 1'b1;
                    w_req.wr_addr = r_idx;
                    w_req.wr_key  = r_key;
                    w_req.wr_sum  = hgsa_pkg::SUM_W'(r_price);
                    n_res_status  = hgsa_pkg::STS_INSERTED;
                    n_res_slot    = hgsa_pkg::SLOT_W'(r_idx);
                    n_res_key     = r_key;
                    n_res_sum     = hgsa_pkg::SUM_W'(r_price);
                    n_state       = ST_DONE;
                end else if (w_last) begin
                    // table full: report the home slot, which is occupied
                    n_res_status = hgsa_pkg::STS_FULL;
                    n_res_slot   = hgsa_pkg::SLOT_W'(r_home);
                    n_res_key    = (r_cnt == '0) ? w_rsp.key : r_hkey;
                    n_res_sum    = (r_cnt == '0) ? w_rsp.sum : r_hsum;
                    n_state      = ST_DONE;
                end else begin
                    w_req.rd_en   = 1'b1;
                    w_req.rd_addr = w_idx_next;
                    n_idx         = w_idx_next;
                    n_cnt         = r_cnt + 1'b1;
                end
            end
            ST_RDATA: begin
                n_res_slot = r_sidx;
                if (w_empty) begin
                    n_res_status = hgsa_pkg::STS_RD_EMPTY;
                    n_res_key    = hgsa_pkg::VACANT_KEY;
                    n_res_sum    = '0;
                end else begin
                    n_res_status = hgsa_pkg::STS_RD_OCC;
                    n_res_key    = w_rsp.key;
                    n_res_sum    = w_rsp.sum;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_m_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (w_m_load) begin
            n_m_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_price      <= n_price;
        r_s          <= n_s;
        r_sidx       <= n_sidx;
        r_idx        <= n_idx;
        r_home       <= n_home;
        r_cnt        <= n_cnt;
        r_hkey       <= n_hkey;
        r_hsum       <= n_hsum;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_key    <= n_res_key;
        r_res_sum    <= n_res_sum;
        if (w_m_load) begin
            r_m_status <= r_res_status;
            r_m_slot   <= r_res_slot;
            r_m_key    <= r_res_key;
            r_m_sum    <= r_res_sum;
        end
    end

    // ---------------- result stream ----------------
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {{(hgsa_pkg::OUT_TDATA_W - hgsa_pkg::SUM_W - hgsa_pkg::KEY_W
                             - hgsa_pkg::SLOT_W){1'b0}}, r_m_sum, r_m_key, r_m_slot};

`ifndef SYNTH
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_busy |-> !s_axis_tready)
        else $error("item accepted during clear sweep");
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> ((r_cnt < r_s) && (hgsa_pkg::SLOT_CW'(r_idx) < r_s)))
        else $error("probe ran past slots in use");
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_m_load |=> (m_axis_tvalid && (r_state == ST_IDLE)))
        else $error("result load did not return to idle");
    a_write_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.wr_en |-> ((r_state == ST_CHECK) && (w_hit || w_empty)))
        else $error("slot write outside a hit or insert");
`endif

endmodule

### hw/rtl/hgsa_hash.sv
// Two-stage home slot hash: (key * golden ratio) mod 2^32, scaled by slots-1.
// Depends on hgsa_pkg.
module hgsa_hash (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hgsa_pkg::KEY_W-1:0]    i_key,
    input  logic [hgsa_pkg::SLOT_AW-1:0]  i_s_m1,
    output logic                          o_valid,
    output logic [hgsa_pkg::SLOT_AW-1:0]  o_home
);

    logic [31:0]                   r_p1;
    logic [hgsa_pkg::SLOT_AW-1:0]  r_sm1;
    logic [hgsa_pkg::SLOT_AW-1:0]  r_home;
    logic                          r_v1;
    logic                          r_v2;
    logic [63:0]                   w_p1_full;
    logic [32+hgsa_pkg::SLOT_AW-1:0] w_p2;

    assign w_p1_full = i_key * hgsa_pkg::HASH_MUL;
    assign w_p2      = r_p1 * r_sm1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p1  <= w_p1_full[31:0];
            r_sm1 <= i_s_m1;
        end
        r_home <= w_p2[32+hgsa_pkg::SLOT_AW-1:32];
    end

    assign o_valid = r_v2;
    assign o_home  = r_home;

endmodule

### hw/rtl/hgsa_mem.sv
// Slot memory: key and sum per slot, one write and one registered read port.
// Sweeps every key to empty after reset. Depends on hgsa_pkg.
module hgsa_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hgsa_pkg::t_mem_req i_req,
    output hgsa_pkg::t_mem_rsp o_rsp,
    output logic               o_busy
);

    logic [hgsa_pkg::ENTRY_W-1:0] r_mem [hgsa_pkg::SLOTS];
    logic [hgsa_pkg::ENTRY_W-1:0] r_rd_data;
    logic                         r_clr_busy;
    logic [hgsa_pkg::SLOT_AW-1:0] r_clr_addr;
    logic                         w_wr_en;
    logic [hgsa_pkg::SLOT_AW-1:0] w_wr_addr;
    logic [hgsa_pkg::ENTRY_W-1:0] w_wr_data;

    // clear sweep owns the write port while busy
    always_comb begin
        if (r_clr_busy) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = {hgsa_pkg::VACANT_KEY, {hgsa_pkg::SUM_W{1'b0}}};
        end else begin
            w_wr_en   = i_req.wr_en;
            w_wr_addr = i_req.wr_addr;
            w_wr_data = {i_req.wr_key, i_req.wr_sum};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == hgsa_pkg::SLOT_AW'(hgsa_pkg::SLOTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rsp  = hgsa_pkg::t_mem_rsp'(r_rd_data);
    assign o_busy = r_clr_busy;

`ifndef SYNTH
    a_no_same_addr_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.rd_en && i_req.wr_en) |-> (i_req.rd_addr != i_req.wr_addr))
        else $error("read and write to one slot in the same cycle");
    a_no_req_while_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!i_req.wr_en && !i_req.rd_en))
        else $error("access during clear sweep");
`endif

endmodule
